>>> hdl/chs_pkg.sv
// shared types and constants for the cosine hemisphere sampler
// no dependencies; every other file but chs_queue imports this package
`default_nettype none

package chs_pkg;

    typedef struct packed {
        logic [15:0] u_sample;
        logic [15:0] v_sample;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic [15:0]        z_out;
        logic [14:0]        pdf_out;
    } dir_t;

    // quarter of the square the point falls in: east, north, west, south
    typedef enum logic [1:0] {
        WEDGE_E,
        WEDGE_N,
        WEDGE_W,
        WEDGE_S
    } wedge_t;

    typedef struct packed {
        logic   neg;
        wedge_t wedge;
    } cls_t;

    typedef struct packed {
        logic [29:0] w;
        logic [29:0] w2;
        cls_t        cls;
    } trig_t;

    localparam int          TMAG_W          = 31;
    localparam logic [30:0] QONE            = 31'h4000_0000;
    localparam logic [29:0] PI_OVER_4_Q30   = 30'd843314857;
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [60:0] HALF_Q30        = 61'd1 << 29;

endpackage

`default_nettype wire

>>> hdl/chs_front.sv
// front end: takes a sample pair, picks the wedge, radius and ratio numerator
// depends on chs_pkg
`default_nettype none

module chs_front
    import chs_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int RW          = SAMPLE_BITS + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    output logic          stall,
    input  sample_t       sample,
    output logic          push_valid,
    input  logic          push_full,
    output logic [RW-1:0] push_r,
    output logic [RW-1:0] push_nm,
    output cls_t          push_cls
);

    localparam int AW = SAMPLE_BITS + 2;
    localparam int UW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam logic signed [AW-1:0] ONE_S = AW'(1) << SAMPLE_BITS;

    logic [AW-1:0]        u_x;
    logic [AW-1:0]        v_x;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW:0]   sum;
    logic [RW-1:0]        abs_a;
    logic [RW-1:0]        abs_b;
    logic [RW-1:0]        r_next;
    logic [RW-1:0]        nm_next;
    cls_t                 cls_next;

    logic                 st_vld_reg;
    logic                 st_vld_next;
    logic [RW-1:0]        st_r_reg;
    logic [RW-1:0]        st_nm_reg;
    cls_t                 st_cls_reg;

    always_comb
    begin
        u_x   = AW'(sample.u_sample[UW-1:0]);
        v_x   = AW'(sample.v_sample[UW-1:0]);
        a     = $signed(u_x << 1) - ONE_S;
        b     = $signed(v_x << 1) - ONE_S;
        sum   = {a[AW-1], a} + {b[AW-1], b};
        abs_a = RW'(a[AW-1] ? -a : a);
        abs_b = RW'(b[AW-1] ? -b : b);
        if (!sum[AW] && sum != '0)
        begin
            if (a > b)
            begin
                r_next         = abs_a;
                nm_next        = abs_b;
                cls_next.neg   = b[AW-1];
                cls_next.wedge = WEDGE_E;
            end
            else
            begin
                r_next         = abs_b;
                nm_next        = abs_a;
                cls_next.neg   = !a[AW-1] && (a != '0);
                cls_next.wedge = WEDGE_N;
            end
        end
        else
        begin
            if (a < b)
            begin
                r_next         = abs_a;
                nm_next        = abs_b;
                cls_next.neg   = !b[AW-1] && (b != '0);
                cls_next.wedge = WEDGE_W;
            end
            else
            begin
                r_next         = abs_b;
                nm_next        = abs_a;
                cls_next.neg   = a[AW-1];
                cls_next.wedge = WEDGE_S;
            end
        end
    end

    assign stall       = st_vld_reg && push_full;
    assign st_vld_next = stall ? st_vld_reg : valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= 1'b0;
        end
        else
        begin
            st_vld_reg <= st_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            st_r_reg   <= r_next;
            st_nm_reg  <= nm_next;
            st_cls_reg <= cls_next;
        end
    end

    assign push_valid = st_vld_reg;
    assign push_r     = st_r_reg;
    assign push_nm    = st_nm_reg;
    assign push_cls   = st_cls_reg;

endmodule

`default_nettype wire

>>> hdl/chs_queue.sv
// four-entry queue between the front end and the arithmetic pipeline
// no package dependencies
`default_nettype none

module chs_queue
#(
    parameter int W = 37
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         nonempty,
    output logic [W-1:0] rdata
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;

    assign full     = (cnt_reg == (PW+1)'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/chs_divider.sv
// restoring divider, one quotient bit per stage: tmag = floor(nm * 2^30 / r)
// depends on chs_pkg
`default_nettype none

module chs_divider
    import chs_pkg::*;
#(
    parameter int RW = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [RW-1:0]     r_in,
    input  logic [RW-1:0]     nm_in,
    input  cls_t              cls_in,
    output logic              vld_out,
    output logic [RW-1:0]     r_out,
    output cls_t              cls_out,
    output logic [TMAG_W-1:0] tmag
);

    logic              vld_reg [TMAG_W];
    logic [RW-1:0]     r_reg   [TMAG_W];
    logic [RW-1:0]     rem_reg [TMAG_W];
    cls_t              cls_reg [TMAG_W];
    logic [TMAG_W-1:0] q_reg   [TMAG_W];

    for (genvar j = 0; j < TMAG_W; j++)
    begin : g_stage
        logic [RW:0]       p;
        logic [RW-1:0]     rd;
        logic [TMAG_W-1:0] qp;
        logic              vp;
        cls_t              cp;
        logic              ge;

        if (j == 0)
        begin : g_head
            assign p  = {1'b0, nm_in};
            assign rd = r_in;
            assign qp = '0;
            assign vp = vld_in;
            assign cp = cls_in;
        end
        else
        begin : g_body
            assign p  = {rem_reg[j-1], 1'b0};
            assign rd = r_reg[j-1];
            assign qp = q_reg[j-1];
            assign vp = vld_reg[j-1];
            assign cp = cls_reg[j-1];
        end

        assign ge = (p >= {1'b0, rd});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vp;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= rd;
                cls_reg[j] <= cp;
                q_reg[j]   <= {qp[TMAG_W-2:0], ge};
                rem_reg[j] <= ge ? RW'(p - {1'b0, rd}) : RW'(p);
            end
        end
    end

    assign vld_out = vld_reg[TMAG_W-1];
    assign r_out   = r_reg[TMAG_W-1];
    assign cls_out = cls_reg[TMAG_W-1];
    assign tmag    = q_reg[TMAG_W-1];

endmodule

`default_nettype wire

>>> hdl/chs_kstep.sv
// one horner step for the sine and cosine series side by side:
// k_next = 1 - round(w2 * k) / d, the division done by reciprocal and correction
// depends on chs_pkg
`default_nettype none

module chs_kstep
    import chs_pkg::*;
#(
    parameter int DS = 42,
    parameter int DC = 56,
    parameter int RW = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  trig_t         trig_in,
    input  logic [RW-1:0] r_in,
    input  logic [30:0]   ks_in,
    input  logic [30:0]   kc_in,
    output logic          vld_out,
    output trig_t         trig_out,
    output logic [RW-1:0] r_out,
    output logic [30:0]   ks_out,
    output logic [30:0]   kc_out
);

    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

    logic          vld_reg  [3];
    trig_t         trig_reg [3];
    logic [RW-1:0] r_reg    [3];

    logic [60:0]   prs_reg;
    logic [60:0]   prc_reg;
    logic [30:0]   ms_reg;
    logic [30:0]   mc_reg;
    logic [30:0]   ms_next;
    logic [30:0]   mc_next;
    logic [62:0]   pqs_reg;
    logic [62:0]   pqc_reg;
    logic [30:0]   ks_reg;
    logic [30:0]   kc_reg;
    logic [30:0]   ks_next;
    logic [30:0]   kc_next;
    logic [30:0]   q0s;
    logic [30:0]   q0c;
    logic [30:0]   rems;
    logic [30:0]   remc;

    always_comb
    begin
        ms_next = 31'((prs_reg + HALF_Q30) >> 30);
        mc_next = 31'((prc_reg + HALF_Q30) >> 30);
        // reciprocal estimate is low by at most one
        q0s     = 31'(pqs_reg >> 32);
        q0c     = 31'(pqc_reg >> 32);
        rems    = ms_reg - 31'(q0s * 31'(DS));
        remc    = mc_reg - 31'(q0c * 31'(DC));
        ks_next = QONE - ((rems >= 31'(DS)) ? q0s + 31'd1 : q0s);
        kc_next = QONE - ((remc >= 31'(DC)) ? q0c + 31'd1 : q0c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
            vld_reg[2] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg[0] <= trig_in;
            trig_reg[1] <= trig_reg[0];
            trig_reg[2] <= trig_reg[1];
            r_reg[0]    <= r_in;
            r_reg[1]    <= r_reg[0];
            r_reg[2]    <= r_reg[1];
            prs_reg     <= 61'(trig_in.w2) * 61'(ks_in);
            prc_reg     <= 61'(trig_in.w2) * 61'(kc_in);
            ms_reg      <= ms_next;
            mc_reg      <= mc_next;
            pqs_reg     <= 63'(ms_next) * 63'(MS);
            pqc_reg     <= 63'(mc_next) * 63'(MC);
            ks_reg      <= ks_next;
            kc_reg      <= kc_next;
        end
    end

    assign vld_out  = vld_reg[2];
    assign trig_out = trig_reg[2];
    assign r_out    = r_reg[2];
    assign ks_out   = ks_reg;
    assign kc_out   = kc_reg;

endmodule

`default_nettype wire

>>> hdl/chs_back.sv
// back end: angle, sine/cosine series, scaling, lift to the hemisphere and pdf
// depends on chs_pkg, chs_divider, chs_kstep
`default_nettype none

module chs_back
    import chs_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int RW          = SAMPLE_BITS + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  logic [RW-1:0] head_r,
    input  logic [RW-1:0] head_nm,
    input  cls_t          head_cls,
    output logic          pop,
    output logic          valid,
    input  logic          stall,
    output dir_t          result
);

    localparam int PW = RW + 31;
    localparam int SH = SAMPLE_BITS + 15;
    localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);
    localparam int ZB = 16;

    function automatic logic [15:0] sat_coord(input logic [16:0] v, input logic neg);
        logic [16:0] m;
        if (neg)
        begin
            m = (v > 17'd32768) ? 17'd32768 : v;
            return 16'(-m);
        end
        m = (v > 17'd32767) ? 17'd32767 : v;
        return m[15:0];
    endfunction

    logic adv;
    logic out_vld_reg;
    dir_t out_reg;

    assign adv = !out_vld_reg || !stall;
    assign pop = adv && head_valid;

    // quotient
    logic              d_vld;
    logic [RW-1:0]     d_r;
    cls_t              d_cls;
    logic [TMAG_W-1:0] d_tmag;

    chs_divider #(.RW(RW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (head_valid),
        .r_in    (head_r),
        .nm_in   (head_nm),
        .cls_in  (head_cls),
        .vld_out (d_vld),
        .r_out   (d_r),
        .cls_out (d_cls),
        .tmag    (d_tmag)
    );

    // angle w and its square
    logic          a1_vld_reg;
    logic [60:0]   a1_prod_reg;
    logic [RW-1:0] a1_r_reg;
    cls_t          a1_cls_reg;
    logic          a2_vld_reg;
    logic [29:0]   a2_w_reg;
    logic [29:0]   w_next;
    logic [60:0]   a2_sq_reg;
    logic [RW-1:0] a2_r_reg;
    cls_t          a2_cls_reg;
    trig_t         a_trig;

    assign w_next = 30'((a1_prod_reg + HALF_Q30) >> 30);

    always_comb
    begin
        a_trig.w   = a2_w_reg;
        a_trig.w2  = 30'((a2_sq_reg + HALF_Q30) >> 30);
        a_trig.cls = a2_cls_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a1_vld_reg <= d_vld;
            a2_vld_reg <= a1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_prod_reg <= 61'(d_tmag) * 61'(PI_OVER_4_Q30);
            a1_r_reg    <= d_r;
            a1_cls_reg  <= d_cls;
            a2_w_reg    <= w_next;
            a2_sq_reg   <= 61'(w_next) * 61'(w_next);
            a2_r_reg    <= a1_r_reg;
            a2_cls_reg  <= a1_cls_reg;
        end
    end

    // three horner steps, sine and cosine in parallel
    logic          k_vld [4];
    trig_t         k_trig [4];
    logic [RW-1:0] k_r [4];
    logic [30:0]   k_s [4];
    logic [30:0]   k_c [4];

    assign k_vld[0]  = a2_vld_reg;
    assign k_trig[0] = a_trig;
    assign k_r[0]    = a2_r_reg;
    assign k_s[0]    = QONE;
    assign k_c[0]    = QONE;

    chs_kstep #(.DS(42), .DC(56), .RW(RW)) u_k3 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .vld_in(k_vld[0]), .trig_in(k_trig[0]), .r_in(k_r[0]),
        .ks_in(k_s[0]), .kc_in(k_c[0]),
        .vld_out(k_vld[1]), .trig_out(k_trig[1]), .r_out(k_r[1]),
        .ks_out(k_s[1]), .kc_out(k_c[1])
    );

    chs_kstep #(.DS(20), .DC(30), .RW(RW)) u_k2 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .vld_in(k_vld[1]), .trig_in(k_trig[1]), .r_in(k_r[1]),
        .ks_in(k_s[1]), .kc_in(k_c[1]),
        .vld_out(k_vld[2]), .trig_out(k_trig[2]), .r_out(k_r[2]),
        .ks_out(k_s[2]), .kc_out(k_c[2])
    );

    chs_kstep #(.DS(6), .DC(12), .RW(RW)) u_k1 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .vld_in(k_vld[2]), .trig_in(k_trig[2]), .r_in(k_r[2]),
        .ks_in(k_s[2]), .kc_in(k_c[2]),
        .vld_out(k_vld[3]), .trig_out(k_trig[3]), .r_out(k_r[3]),
        .ks_out(k_s[3]), .kc_out(k_c[3])
    );

    // final products, then sine, cosine and the wedge rotation
    logic          f1_vld_reg;
    logic [60:0]   f1_ps_reg;
    logic [60:0]   f1_pc_reg;
    logic [RW-1:0] f1_r_reg;
    cls_t          f1_cls_reg;
    logic [30:0]   sn;
    logic [30:0]   cs;
    logic signed [31:0] sl;
    logic signed [31:0] cl;
    logic signed [31:0] cx;
    logic signed [31:0] sy;
    logic          f2_vld_reg;
    logic [30:0]   f2_mx_reg;
    logic [30:0]   f2_my_reg;
    logic          f2_nx_reg;
    logic          f2_ny_reg;
    logic [RW-1:0] f2_r_reg;

    always_comb
    begin
        sn = 31'((f1_ps_reg + HALF_Q30) >> 30);
        cs = QONE - (31'((f1_pc_reg + HALF_Q30) >> 30) >> 1);
        cl = $signed({1'b0, cs});
        sl = f1_cls_reg.neg ? -$signed({1'b0, sn}) : $signed({1'b0, sn});
        case (f1_cls_reg.wedge)
            WEDGE_E:
            begin
                cx = cl;
                sy = sl;
            end
            WEDGE_N:
            begin
                cx = -sl;
                sy = cl;
            end
            WEDGE_W:
            begin
                cx = -cl;
                sy = -sl;
            end
            WEDGE_S:
            begin
                cx = sl;
                sy = -cl;
            end
            default:
            begin
                cx = cl;
                sy = sl;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= k_vld[3];
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_ps_reg  <= 61'(k_trig[3].w) * 61'(k_s[3]);
            f1_pc_reg  <= 61'(k_trig[3].w2) * 61'(k_c[3]);
            f1_r_reg   <= k_r[3];
            f1_cls_reg <= k_trig[3].cls;
            f2_nx_reg  <= cx[31];
            f2_ny_reg  <= sy[31];
            f2_mx_reg  <= 31'(cx[31] ? -cx : cx);
            f2_my_reg  <= 31'(sy[31] ? -sy : sy);
            f2_r_reg   <= f1_r_reg;
        end
    end

    // scale by the radius, round and saturate to q1.15
    logic          s1_vld_reg;
    logic [PW-1:0] s1_px_reg;
    logic [PW-1:0] s1_py_reg;
    logic          s1_nx_reg;
    logic          s1_ny_reg;
    logic          s2_vld_reg;
    logic [15:0]   s2_x_reg;
    logic [15:0]   s2_y_reg;
    logic [16:0]   vx;
    logic [16:0]   vy;

    assign vx = 17'((s1_px_reg + RND) >> SH);
    assign vy = 17'((s1_py_reg + RND) >> SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= f2_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg <= PW'(f2_r_reg) * PW'(f2_mx_reg);
            s1_py_reg <= PW'(f2_r_reg) * PW'(f2_my_reg);
            s1_nx_reg <= f2_nx_reg;
            s1_ny_reg <= f2_ny_reg;
            s2_x_reg  <= sat_coord(vx, s1_nx_reg);
            s2_y_reg  <= sat_coord(vy, s1_ny_reg);
        end
    end

    // 1 - x^2 - y^2, clamped at zero
    logic               q1_vld_reg;
    logic [30:0]        q1_xx_reg;
    logic [30:0]        q1_yy_reg;
    logic [15:0]        q1_x_reg;
    logic [15:0]        q1_y_reg;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic [32:0]        rem;

    assign xs  = 32'($signed(s2_x_reg));
    assign ys  = 32'($signed(s2_y_reg));
    assign rem = 33'(QONE) - 33'(q1_xx_reg) - 33'(q1_yy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            q1_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_xx_reg <= 31'(xs * xs);
            q1_yy_reg <= 31'(ys * ys);
            q1_x_reg  <= s2_x_reg;
            q1_y_reg  <= s2_y_reg;
        end
    end

    // integer square root, one root bit per stage; entry 0 holds the radicand
    logic        sq_vld_reg [ZB+1];
    logic [30:0] sq_rm_reg  [ZB+1];
    logic [15:0] sq_rt_reg  [ZB+1];
    logic [15:0] sq_x_reg   [ZB+1];
    logic [15:0] sq_y_reg   [ZB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= q1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rm_reg[0] <= rem[32] ? 31'd0 : rem[30:0];
            sq_rt_reg[0] <= '0;
            sq_x_reg[0]  <= q1_x_reg;
            sq_y_reg[0]  <= q1_y_reg;
        end
    end

    for (genvar j = 0; j < ZB; j++)
    begin : g_sqrt
        localparam int BI = ZB - 1 - j;
        logic [32:0] trial;
        logic        ge;

        assign trial = (33'(sq_rt_reg[j]) << (BI + 1)) + (33'(1) << (2 * BI));
        assign ge    = (33'(sq_rm_reg[j]) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rm_reg[j+1] <= ge ? 31'(33'(sq_rm_reg[j]) - trial) : sq_rm_reg[j];
                sq_rt_reg[j+1] <= ge ? (sq_rt_reg[j] | (16'(1) << BI)) : sq_rt_reg[j];
                sq_x_reg[j+1]  <= sq_x_reg[j];
                sq_y_reg[j+1]  <= sq_y_reg[j];
            end
        end
    end

    // pdf = z * 2/pi, rounded
    logic        p1_vld_reg;
    logic [47:0] p1_pp_reg;
    logic [15:0] p1_z_reg;
    logic [15:0] p1_x_reg;
    logic [15:0] p1_y_reg;
    dir_t        out_next;

    always_comb
    begin
        out_next.x_out   = $signed(p1_x_reg);
        out_next.y_out   = $signed(p1_y_reg);
        out_next.z_out   = p1_z_reg;
        out_next.pdf_out = 15'((p1_pp_reg + 48'h8000_0000) >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg  <= sq_vld_reg[ZB];
            out_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_pp_reg <= 48'(sq_rt_reg[ZB]) * 48'(TWO_OVER_PI_Q32);
            p1_z_reg  <= sq_rt_reg[ZB];
            p1_x_reg  <= sq_x_reg[ZB];
            p1_y_reg  <= sq_y_reg[ZB];
            out_reg   <= out_next;
        end
    end

    assign valid  = out_vld_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

>>> hdl/cosine_hemisphere_sampler_top.sv
// channel  | direction | payload  | handshake
// sample   | in        | sample_t | sample_valid / sample_stall
// result   | out       | dir_t    | result_valid / result_stall
//
// one transfer in and one result out per cycle when neither side stalls
// latency is set mostly by the 31-stage divider and the 16-stage square
// root in the back end
// reset clears only the valid bits and the queue pointers and count; no sweep after reset
// a stall on a valid result freezes the back end; the four-entry queue
// and the front register keep taking samples until the queue fills
//
// top level; depends on chs_pkg, chs_front, chs_queue, chs_back
`default_nettype none

module cosine_hemisphere_sampler_top
    import chs_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output dir_t    result
);

    localparam int RW = SAMPLE_BITS + 1;
    localparam int QW = 2 * RW + $bits(cls_t);

    logic          f_valid;
    logic [RW-1:0] f_r;
    logic [RW-1:0] f_nm;
    cls_t          f_cls;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_nonempty;
    logic [QW-1:0] q_rdata;
    logic [RW-1:0] h_r;
    logic [RW-1:0] h_nm;
    cls_t          h_cls;

    chs_front #(.SAMPLE_BITS(SAMPLE_BITS), .RW(RW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (sample_valid),
        .stall      (sample_stall),
        .sample     (sample),
        .push_valid (f_valid),
        .push_full  (q_full),
        .push_r     (f_r),
        .push_nm    (f_nm),
        .push_cls   (f_cls)
    );

    assign q_push = f_valid && !q_full;

    chs_queue #(.W(QW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    ({f_r, f_nm, f_cls}),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .rdata    (q_rdata)
    );

    assign {h_r, h_nm, h_cls} = q_rdata;

    chs_back #(.SAMPLE_BITS(SAMPLE_BITS), .RW(RW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_nonempty),
        .head_r     (h_r),
        .head_nm    (h_nm),
        .head_cls   (h_cls),
        .pop        (q_pop),
        .valid      (result_valid),
        .stall      (result_stall),
        .result     (result)
    );

endmodule

`default_nettype wire

>>> hdl/chs_checker.sv
// port-level checks on the result channel, bound to the top level
// depends on chs_pkg and cosine_hemisphere_sampler_top
`default_nettype none

module chs_checker
    import chs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic result_valid,
    input logic result_stall,
    input dir_t result
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.z_out <= 16'd32768)
        else $error("z above one");

    a_pdf_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pdf_out <= 15'd20861)
        else $error("pdf above one over pi");

    a_centre_pole: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.x_out == 16'sd0 && result.y_out == 16'sd0
            |-> result.z_out == 16'd32768)
        else $error("zero disk point not lifted to the pole");

endmodule

bind cosine_hemisphere_sampler_top chs_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
